>>> hw/rtl/msag_pkg.sv
package msag_pkg;

   localparam int MAX_CELL_WIDTH  = 256;
   localparam int MAX_CELL_HEIGHT = 256;
   localparam int MAX_LAYERS      = 16;
   localparam int MAX_CELLS       = 16;

   localparam int EXT_W    = 30;
   localparam int SRC_W    = 28;
   localparam int DATA_W   = 64;
   localparam int SIZE_W   = 9;
   localparam int COUNT_W  = 5;
   localparam int LAYER_W  = 4;
   localparam int POS_W    = 8;
   localparam int CELL_W   = 4;
   localparam int MCELL_W  = 5;
   localparam int ECELL_W  = 6;
   localparam int MUL_B_W  = 9;
   localparam int ADD_W    = 8;
   localparam int PROD_W   = EXT_W + MUL_B_W;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_HEIGHT    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_ACROSS   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_DOWN     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_X       = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_Y       = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_MODE = 4'd7;

   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [COUNT_W-1:0] count_type;

   function automatic size_type clamp_size(input size_type v, input int maxv);
      size_type r;
      if (v == '0) begin
         r = size_type'(1);
      end else if (int'(v) > maxv) begin
         r = size_type'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic count_type clamp_count(input count_type v, input int maxv);
      count_type r;
      if (v == '0) begin
         r = count_type'(1);
      end else if (int'(v) > maxv) begin
         r = count_type'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/msag_mac.sv
module msag_mac
   import msag_pkg::*;
(
   input  logic [EXT_W-1:0]   mul_a,
   input  logic [MUL_B_W-1:0] mul_b,
   input  logic [ADD_W-1:0]   add_c,
   output logic [EXT_W-1:0]   result
);

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] sum;

   assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign sum    = prod + PROD_W'(add_c);
   assign result = sum[EXT_W-1:0];

endmodule

>>> hw/rtl/mirror_symmetry_address_gen.sv
// The first result word follows the source index and the direct copy's index.
// Each input word yields 1, 2 or 4 copies, and the next one is taken only when idle;
// each index is four multiply-add steps through the one shared unit, source first.
// Reset: sizes to 1, mirror and transpose off, sweep counters to zero, no result word.
// Any write to a known register restarts the sweep.
module mirror_symmetry_address_gen
   import msag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_element_value,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [EXT_W-1:0]      rsp_ext_index,
   output logic [SRC_W-1:0]      rsp_src_index,
   output logic [DATA_W-1:0]     rsp_copy_value,
   output logic                  rsp_last_copy,
   output logic                  rsp_last_element,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam logic [2:0] CP_SRC    = 3'd0;
   localparam logic [2:0] CP_DIRECT = 3'd1;
   localparam logic [2:0] CP_XM     = 3'd2;
   localparam logic [2:0] CP_YM     = 3'd3;
   localparam logic [2:0] CP_BOTH   = 3'd4;

   localparam logic [1:0] STEP_CELL  = 2'd0;
   localparam logic [1:0] STEP_Y     = 2'd1;
   localparam logic [1:0] STEP_X     = 2'd2;
   localparam logic [1:0] STEP_LAYER = 2'd3;

   // control
   logic [1:0]         state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic [2:0]         copy_ff, copy_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // configuration, held clamped
   logic [SIZE_W-1:0]  w_ff, w_in;
   logic [SIZE_W-1:0]  h_ff, h_in;
   logic [COUNT_W-1:0] nl_ff, nl_in;
   logic [COUNT_W-1:0] ncx_ff, ncx_in;
   logic [COUNT_W-1:0] ncy_ff, ncy_in;
   logic               mx_ff, mx_in;
   logic               my_ff, my_in;
   logic               tr_ff, tr_in;

   // sweep counters
   logic [LAYER_W-1:0] lp_ff, lp_in;
   logic [POS_W-1:0]   xp_ff, xp_in;
   logic [POS_W-1:0]   yp_ff, yp_in;
   logic [CELL_W-1:0]  cxp_ff, cxp_in;
   logic [CELL_W-1:0]  cyp_ff, cyp_in;

   // current element
   logic [LAYER_W-1:0] wl_ff, wl_in;
   logic [POS_W-1:0]   wx0_ff, wx0_in, wx1_ff, wx1_in;
   logic [POS_W-1:0]   wy0_ff, wy0_in, wy1_ff, wy1_in;
   logic [MCELL_W-1:0] wcx0_ff, wcx0_in, wcx1_ff, wcx1_in;
   logic [MCELL_W-1:0] wcy0_ff, wcy0_in, wcy1_ff, wcy1_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic               lelem_ff, lelem_in;
   logic [EXT_W-1:0]   acc_ff, acc_in;
   logic [SRC_W-1:0]   src_ff, src_in;

   // result word
   logic [EXT_W-1:0]   rext_ff, rext_in;
   logic [SRC_W-1:0]   rsrc_ff, rsrc_in;
   logic [DATA_W-1:0]  rval_ff, rval_in;
   logic               rlc_ff, rlc_in;
   logic               rle_ff, rle_in;

   logic               req_accept;
   logic               csr_write;
   logic               slot_free;
   logic               sel_mx, sel_my;
   logic [POS_W-1:0]   sel_x, sel_y;
   logic [MCELL_W-1:0] sel_cx, sel_cy;
   logic [ECELL_W-1:0] sel_e;
   logic [2:0]         copy_nx;
   logic               copy_end;
   logic [EXT_W-1:0]   mac_a;
   logic [MUL_B_W-1:0] mac_b;
   logic [ADD_W-1:0]   mac_c;
   logic [EXT_W-1:0]   mac_y;
   logic               load_out;
   logic [EXT_W-1:0]   load_idx;

   msag_mac u_mac (
      .mul_a  (mac_a),
      .mul_b  (mac_b),
      .add_c  (mac_c),
      .result (mac_y)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ext_index    = rext_ff;
   assign rsp_src_index    = rsrc_ff;
   assign rsp_copy_value   = rval_ff;
   assign rsp_last_copy    = rlc_ff;
   assign rsp_last_element = rle_ff;

   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign sel_mx = (copy_ff == CP_XM) || (copy_ff == CP_BOTH);
   assign sel_my = (copy_ff == CP_YM) || (copy_ff == CP_BOTH);
   assign sel_x  = sel_mx ? wx1_ff : wx0_ff;
   assign sel_cx = sel_mx ? wcx1_ff : wcx0_ff;
   assign sel_y  = sel_my ? wy1_ff : wy0_ff;
   assign sel_cy = sel_my ? wcy1_ff : wcy0_ff;
   assign sel_e  = (copy_ff != CP_SRC && mx_ff) ? {ncx_ff, 1'b0} : {1'b0, ncx_ff};

   always_comb begin
      copy_nx = CP_DIRECT;
      unique case (copy_ff)
         CP_SRC:    copy_nx = CP_DIRECT;
         CP_DIRECT: copy_nx = mx_ff ? CP_XM : CP_YM;
         CP_XM:     copy_nx = CP_YM;
         CP_YM:     copy_nx = CP_BOTH;
         default:   copy_nx = CP_DIRECT;
      endcase
   end

   always_comb begin
      unique case (copy_ff)
         CP_DIRECT: copy_end = !mx_ff && !my_ff;
         CP_XM:     copy_end = !my_ff;
         CP_YM:     copy_end = !mx_ff;
         default:   copy_end = (copy_ff == CP_BOTH);
      endcase
   end

   always_comb begin
      unique case (step_ff)
         STEP_CELL: begin
            mac_a = EXT_W'(sel_cy);
            mac_b = MUL_B_W'(sel_e);
            mac_c = ADD_W'(sel_cx);
         end
         STEP_Y: begin
            mac_a = acc_ff;
            mac_b = h_ff;
            mac_c = sel_y;
         end
         STEP_X: begin
            mac_a = acc_ff;
            mac_b = w_ff;
            mac_c = sel_x;
         end
         default: begin
            mac_a = acc_ff;
            mac_b = MUL_B_W'(nl_ff);
            mac_c = ADD_W'(wl_ff);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      copy_in      = copy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      w_in         = w_ff;
      h_in         = h_ff;
      nl_in        = nl_ff;
      ncx_in       = ncx_ff;
      ncy_in       = ncy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      tr_in        = tr_ff;
      lp_in        = lp_ff;
      xp_in        = xp_ff;
      yp_in        = yp_ff;
      cxp_in       = cxp_ff;
      cyp_in       = cyp_ff;
      wl_in        = wl_ff;
      wx0_in       = wx0_ff;
      wx1_in       = wx1_ff;
      wy0_in       = wy0_ff;
      wy1_in       = wy1_ff;
      wcx0_in      = wcx0_ff;
      wcx1_in      = wcx1_ff;
      wcy0_in      = wcy0_ff;
      wcy1_in      = wcy1_ff;
      data_in      = data_ff;
      lelem_in     = lelem_ff;
      acc_in       = acc_ff;
      src_in       = src_ff;
      rext_in      = rext_ff;
      rsrc_in      = rsrc_ff;
      rval_in      = rval_ff;
      rlc_in       = rlc_ff;
      rle_in       = rle_ff;
      load_out     = 1'b0;
      load_idx     = mac_y;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CALC;
               step_in  = STEP_CELL;
               copy_in  = CP_SRC;
               wl_in    = lp_ff;
               wx0_in   = xp_ff;
               wx1_in   = POS_W'(w_ff - SIZE_W'(1) - SIZE_W'(xp_ff));
               wy0_in   = yp_ff;
               wy1_in   = POS_W'(h_ff - SIZE_W'(1) - SIZE_W'(yp_ff));
               wcx0_in  = MCELL_W'(cxp_ff);
               wcx1_in  = MCELL_W'({ncx_ff, 1'b0} - ECELL_W'(1) - ECELL_W'(cxp_ff));
               wcy0_in  = MCELL_W'(cyp_ff);
               wcy1_in  = MCELL_W'({ncy_ff, 1'b0} - ECELL_W'(1) - ECELL_W'(cyp_ff));
               data_in  = tr_ff ? '0 : req_element_value;
               lelem_in = (COUNT_W'(lp_ff) == nl_ff - COUNT_W'(1)) &&
                          (SIZE_W'(xp_ff) == w_ff - SIZE_W'(1)) &&
                          (SIZE_W'(yp_ff) == h_ff - SIZE_W'(1)) &&
                          (COUNT_W'(cxp_ff) == ncx_ff - COUNT_W'(1)) &&
                          (COUNT_W'(cyp_ff) == ncy_ff - COUNT_W'(1));
               // layers innermost
               if (COUNT_W'(lp_ff) + COUNT_W'(1) < nl_ff) begin
                  lp_in = lp_ff + LAYER_W'(1);
               end else begin
                  lp_in = '0;
                  if (SIZE_W'(xp_ff) + SIZE_W'(1) < w_ff) begin
                     xp_in = xp_ff + POS_W'(1);
                  end else begin
                     xp_in = '0;
                     if (SIZE_W'(yp_ff) + SIZE_W'(1) < h_ff) begin
                        yp_in = yp_ff + POS_W'(1);
                     end else begin
                        yp_in = '0;
                        if (COUNT_W'(cxp_ff) + COUNT_W'(1) < ncx_ff) begin
                           cxp_in = cxp_ff + CELL_W'(1);
                        end else begin
                           cxp_in = '0;
                           if (COUNT_W'(cyp_ff) + COUNT_W'(1) < ncy_ff) begin
                              cyp_in = cyp_ff + CELL_W'(1);
                           end else begin
                              cyp_in = '0;
                           end
                        end
                     end
                  end
               end
            end
         end
         ST_CALC: begin
            acc_in  = mac_y;
            step_in = step_ff + 2'd1;
            if (step_ff == STEP_LAYER) begin
               if (copy_ff == CP_SRC) begin
                  src_in  = mac_y[SRC_W-1:0];
                  copy_in = CP_DIRECT;
               end else if (slot_free) begin
                  load_out = 1'b1;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            load_idx = acc_ff;
            if (slot_free) begin
               load_out = 1'b1;
               state_in = ST_CALC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rext_in      = load_idx;
         rsrc_in      = src_ff;
         rval_in      = data_ff;
         rlc_in       = copy_end;
         rle_in       = lelem_ff;
         if (copy_end) begin
            state_in = ST_IDLE;
         end else begin
            copy_in = copy_nx;
         end
      end

      if (csr_write && csr_index <= CSR_TRANSPOSE_MODE) begin
         unique case (csr_index)
            CSR_CELL_WIDTH:   w_in   = clamp_size(csr_data, MAX_CELL_WIDTH);
            CSR_CELL_HEIGHT:  h_in   = clamp_size(csr_data, MAX_CELL_HEIGHT);
            CSR_LAYER_COUNT:  nl_in  = clamp_count(csr_data[COUNT_W-1:0], MAX_LAYERS);
            CSR_CELLS_ACROSS: ncx_in = clamp_count(csr_data[COUNT_W-1:0], MAX_CELLS);
            CSR_CELLS_DOWN:   ncy_in = clamp_count(csr_data[COUNT_W-1:0], MAX_CELLS);
            CSR_MIRROR_X:     mx_in  = csr_data[0];
            CSR_MIRROR_Y:     my_in  = csr_data[0];
            default:          tr_in  = csr_data[0];
         endcase
         lp_in  = '0;
         xp_in  = '0;
         yp_in  = '0;
         cxp_in = '0;
         cyp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_CELL;
         copy_ff      <= CP_SRC;
         rsp_valid_ff <= 1'b0;
         w_ff         <= SIZE_W'(1);
         h_ff         <= SIZE_W'(1);
         nl_ff        <= COUNT_W'(1);
         ncx_ff       <= COUNT_W'(1);
         ncy_ff       <= COUNT_W'(1);
         mx_ff        <= 1'b0;
         my_ff        <= 1'b0;
         tr_ff        <= 1'b0;
         lp_ff        <= '0;
         xp_ff        <= '0;
         yp_ff        <= '0;
         cxp_ff       <= '0;
         cyp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         copy_ff      <= copy_in;
         rsp_valid_ff <= rsp_valid_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
         nl_ff        <= nl_in;
         ncx_ff       <= ncx_in;
         ncy_ff       <= ncy_in;
         mx_ff        <= mx_in;
         my_ff        <= my_in;
         tr_ff        <= tr_in;
         lp_ff        <= lp_in;
         xp_ff        <= xp_in;
         yp_ff        <= yp_in;
         cxp_ff       <= cxp_in;
         cyp_ff       <= cyp_in;
      end
   end

   always_ff @(posedge clock) begin
      wl_ff    <= wl_in;
      wx0_ff   <= wx0_in;
      wx1_ff   <= wx1_in;
      wy0_ff   <= wy0_in;
      wy1_ff   <= wy1_in;
      wcx0_ff  <= wcx0_in;
      wcx1_ff  <= wcx1_in;
      wcy0_ff  <= wcy0_in;
      wcy1_ff  <= wcy1_in;
      data_ff  <= data_in;
      lelem_ff <= lelem_in;
      acc_ff   <= acc_in;
      src_ff   <= src_in;
      rext_ff  <= rext_in;
      rsrc_ff  <= rsrc_in;
      rval_ff  <= rval_in;
      rlc_ff   <= rlc_in;
      rle_ff   <= rle_in;
   end

endmodule

>>> hw/rtl/msag_checker.sv
module msag_checker
   import msag_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [EXT_W-1:0]      rsp_ext_index,
   input logic [SRC_W-1:0]      rsp_src_index,
   input logic [DATA_W-1:0]     rsp_copy_value,
   input logic                  rsp_last_copy,
   input logic                  rsp_last_element,
   input logic                  csr_ready
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ext_index) &&
      $stable(rsp_src_index) && $stable(rsp_copy_value) && $stable(rsp_last_copy) &&
      $stable(rsp_last_element))
      else $error("result word changed while stalled");

   // no result word straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // an accepted word keeps the unit busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !csr_ready)
      else $error("input taken again one cycle after accept");

   // copies still to come while a non-final copy is shown
   a_busy_mid_element: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_copy |-> req_stall)
      else $error("idle before last copy of element");

endmodule

bind mirror_symmetry_address_gen msag_checker u_msag_checker (.*);
